// ----- hw/rtl/adc_seq_pkg.sv -----
// Package for the ADC scan sequencer: payload types, register indexes and defaults.
`timescale 1ns / 1ps
package adc_seq_pkg;

	// default sequence layout and heartbeat timing
	localparam int NUM_RAW_DEF      = 2;
	localparam int NUM_NON_LINE_DEF = 5;
	localparam int NUM_ALL_DEF      = 13;
	localparam int PERIOD_TICKS_DEF = 100;
	localparam int HALF_OFFSET_DEF  = 60;

	localparam int SAMPLE_W = 12;
	localparam int VALUE_W  = 13;
	localparam int SLOT_W   = 4;
	localparam int PHASE_W  = 7;
	localparam int TICK_W   = 16;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LED_ENABLE  = 1'd1;

	// item kinds
	localparam logic MODE_TICK   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic               period_start;
		logic               start_conv;
		logic [SLOT_W-1:0]  channel;
		logic               slot_write;
		logic [SLOT_W-1:0]  slot;
		logic               bank;
		logic [VALUE_W-1:0] stored_value;
		logic               sequence_done;
		logic               led_on;
		logic [TICK_W-1:0]  convert_ticks;
		logic               dropped;
	} result_t;

endpackage

// ----- hw/rtl/adc_scan_sequencer.sv -----
// ADC scan sequencer: heartbeat phase counter, slot sequencing, filtering and LED control.
`timescale 1ns / 1ps
// Takes one item per clock unless stalled and gives one result per item. An item is held in the
// input register, then the single-pass step logic updates the sequencer state and loads the
// result register once that register is free, and the result can be taken when the output is
// not stalled; throughput is one item per cycle, limited only by the result register draining.
// A tick item advances the phase counter and may start a pass (phase 0: LED-off pass,
// HALF_OFFSET: LED-on pass if idle); a sample item is stored to the current slot, raw,
// low-pass filtered ((old >> 1) + sample) or routed to the line-sensor bank of the pass.
// Samples arriving with no pass running are reported with dropped set. The filter history
// is held in flops and cleared by reset. Configuration writes are always ready.
module adc_scan_sequencer #(
	parameter int NUM_RAW      = adc_seq_pkg::NUM_RAW_DEF,
	parameter int NUM_NON_LINE = adc_seq_pkg::NUM_NON_LINE_DEF,
	parameter int NUM_ALL      = adc_seq_pkg::NUM_ALL_DEF,
	parameter int PERIOD_TICKS = adc_seq_pkg::PERIOD_TICKS_DEF,
	parameter int HALF_OFFSET  = adc_seq_pkg::HALF_OFFSET_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  adc_seq_pkg::item_t                  item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output adc_seq_pkg::result_t                result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [adc_seq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [adc_seq_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import adc_seq_pkg::*;

	localparam int FILT_DEPTH = (NUM_NON_LINE > NUM_RAW) ? (NUM_NON_LINE - NUM_RAW) : 1;
	localparam int FILT_IW    = (FILT_DEPTH > 1) ? $clog2(FILT_DEPTH) : 1;

	localparam logic [SLOT_W-1:0]  RAW_END  = SLOT_W'(NUM_RAW);
	localparam logic [SLOT_W-1:0]  NL_END   = SLOT_W'(NUM_NON_LINE);
	localparam logic [SLOT_W-1:0]  ALL_END  = SLOT_W'(NUM_ALL);
	localparam logic [PHASE_W:0]   PERIOD_C = (PHASE_W+1)'(PERIOD_TICKS);
	localparam logic [PHASE_W-1:0] HALF_C   = PHASE_W'(HALF_OFFSET);

	// configuration
	logic scan_enable_q;
	logic led_enable_q;

	// sequencer state
	logic [PHASE_W-1:0] phase_q,      phase_n;
	logic [TICK_W-1:0]  tick_q,       tick_n;
	logic [SLOT_W-1:0]  seq_q,        seq_n;
	logic               second_q,     second_n;
	logic [TICK_W-1:0]  pass_start_q, pass_start_n;
	logic               led_q,        led_n;
	logic [VALUE_W-1:0] filt_q [FILT_DEPTH];

	// input stage and result register
	logic    item_valid_s1;
	item_t   item_s1;
	logic    result_valid_q;
	result_t result_q;

	logic    out_free;
	logic    step;
	result_t res_n;

	logic               filt_we;
	logic [FILT_IW-1:0] filt_idx;
	logic [SLOT_W-1:0]  filt_k;
	logic [VALUE_W-1:0] filt_old;
	logic [VALUE_W-1:0] filt_val;
	logic [PHASE_W:0]   phase_inc;

	assign out_free     = !result_valid_q || !result_stall;
	assign step         = item_valid_s1 && out_free;
	assign item_stall   = item_valid_s1 && !out_free;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

	assign filt_k   = seq_q - RAW_END;
	assign filt_idx = filt_k[FILT_IW-1:0];
	assign filt_old = filt_q[filt_idx];
	assign filt_val = {1'b0, filt_old[VALUE_W-1:1]} + VALUE_W'(item_s1.sample);

	assign phase_inc = {1'b0, phase_q} + 1'b1;

	always_comb begin
		res_n        = '0;
		phase_n      = phase_q;
		tick_n       = tick_q;
		seq_n        = seq_q;
		second_n     = second_q;
		pass_start_n = pass_start_q;
		led_n        = led_q;
		filt_we      = 1'b0;

		if (item_s1.mode == MODE_TICK) begin
			tick_n  = tick_q + 1'b1;
			phase_n = (phase_inc >= PERIOD_C) ? '0 : phase_inc[PHASE_W-1:0];
			if (phase_n == '0) begin
				res_n.period_start = 1'b1;
				if (scan_enable_q) begin
					seq_n            = '0;
					second_n         = 1'b0;
					pass_start_n     = tick_n;
					res_n.start_conv = 1'b1;
				end
			end
			// phase 0 and the half offset never coincide, so seq_q is the live index here
			if (phase_n == HALF_C && scan_enable_q && seq_q >= ALL_END) begin
				seq_n            = '0;
				second_n         = 1'b1;
				pass_start_n     = tick_n;
				res_n.start_conv = 1'b1;
			end
		end else if (seq_q >= ALL_END) begin
			res_n.dropped = 1'b1;
		end else begin
			res_n.slot_write = 1'b1;
			res_n.slot       = seq_q;
			if (seq_q < RAW_END) begin
				res_n.stored_value = VALUE_W'(item_s1.sample);
			end else if (seq_q < NL_END) begin
				res_n.stored_value = filt_val;
				filt_we            = 1'b1;
			end else begin
				res_n.stored_value = VALUE_W'(item_s1.sample);
				res_n.bank         = second_q;
			end
			seq_n = seq_q + 1'b1;
			if (seq_n < ALL_END) begin
				res_n.start_conv = 1'b1;
				res_n.channel    = seq_n;
			end else begin
				res_n.sequence_done = 1'b1;
				res_n.convert_ticks = tick_q - pass_start_q;
				led_n               = second_q ? led_enable_q : 1'b0;
			end
		end
		res_n.led_on = led_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_enable_q <= 1'b1;
			led_enable_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCAN_ENABLE: scan_enable_q <= cfg_data[0];
				REG_LED_ENABLE:  led_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			tick_q       <= '0;
			seq_q        <= ALL_END;
			second_q     <= 1'b0;
			pass_start_q <= '0;
			led_q        <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_n;
			tick_q       <= tick_n;
			seq_q        <= seq_n;
			second_q     <= second_n;
			pass_start_q <= pass_start_n;
			led_q        <= led_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FILT_DEPTH; i++) begin
				filt_q[i] <= '0;
			end
		end else if (step && filt_we) begin
			filt_q[filt_idx] <= filt_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= res_n;
		end
	end

	// idle is encoded as the slot count; the index never runs past it
	a_seq_range: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q <= ALL_END)
		else $error("slot index beyond idle code");

	a_drop_alone: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.dropped |-> !result.slot_write && !result.start_conv)
		else $error("dropped sample also stored or started a conversion");

	a_done_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.sequence_done |-> !result.start_conv && result.slot_write)
		else $error("pass end requested another conversion");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.slot_write |-> result.slot < ALL_END)
		else $error("stored slot out of range");

	a_led_moves_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && (led_n != led_q) |-> res_n.sequence_done)
		else $error("LED level changed outside a pass end");

endmodule

// ----- tb/adc_scan_sequencer_check.sv -----
// Checker for the ADC scan sequencer: predicts each result from the accepted items and compares.
`timescale 1ns / 1ps
module adc_scan_sequencer_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	input  logic                                item_stall,
	input  adc_seq_pkg::item_t                  item,
	input  logic                                result_valid,
	input  logic                                result_stall,
	input  adc_seq_pkg::result_t                result,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [adc_seq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [adc_seq_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                                  errors,
	output int                                  pending
);
	import adc_seq_pkg::*;

	localparam int NRAW     = NUM_RAW_DEF;
	localparam int NNONLINE = NUM_NON_LINE_DEF;
	localparam int NALL     = NUM_ALL_DEF;
	localparam int PERIOD   = PERIOD_TICKS_DEF;
	localparam int HALF     = HALF_OFFSET_DEF;
	localparam int NFILT    = NNONLINE - NRAW;

	logic [PHASE_W-1:0] phase;
	logic [TICK_W-1:0]  ticks;
	logic [TICK_W-1:0]  pass_t0;
	logic [SLOT_W-1:0]  slot_idx;
	logic               upper_pass;
	logic [VALUE_W-1:0] filt [NFILT];
	logic               led;
	logic               scan_en;
	logic               led_en;

	result_t step_results[$];

	function automatic string show(input result_t r);
		return {$sformatf("ps=%0d sc=%0d ch=%0d sw=%0d sl=%0d bk=%0d ",
				r.period_start, r.start_conv, r.channel, r.slot_write, r.slot, r.bank),
			$sformatf("val=%0d done=%0d led=%0d tk=%0d drop=%0d",
				r.stored_value, r.sequence_done, r.led_on, r.convert_ticks, r.dropped)};
	endfunction

	task automatic pass_begin(input logic half, inout result_t r);
		slot_idx = '0;
		upper_pass = half;
		pass_t0 = ticks;
		r.start_conv = 1'b1;
		r.channel = '0;
	endtask

	task automatic sequence_step(input item_t it, output result_t r);
		int s;
		logic [VALUE_W-1:0] v;
		r = '0;
		if (it.mode == MODE_TICK) begin
			ticks = ticks + 1'b1;
			phase = (int'(phase) + 1 >= PERIOD) ? '0 : phase + 1'b1;
			if (phase == 0) begin
				r.period_start = 1'b1;
				if (scan_en)
					pass_begin(1'b0, r);
			end
			// half scan only when the previous pass has finished
			if (phase == HALF && scan_en && slot_idx >= NALL)
				pass_begin(1'b1, r);
		end else if (slot_idx >= NALL) begin
			r.dropped = 1'b1;
		end else begin
			s = slot_idx;
			if (s < NRAW) begin
				v = it.sample;
			end else if (s < NNONLINE) begin
				v = (filt[s - NRAW] >> 1) + it.sample;
				filt[s - NRAW] = v;
			end else begin
				v = it.sample;
				r.bank = upper_pass;
			end
			r.slot_write = 1'b1;
			r.slot = slot_idx;
			r.stored_value = v;
			slot_idx = slot_idx + 1'b1;
			if (slot_idx < NALL) begin
				r.start_conv = 1'b1;
				r.channel = slot_idx;
			end else begin
				r.sequence_done = 1'b1;
				r.convert_ticks = ticks - pass_t0;
				led = upper_pass ? led_en : 1'b0;
			end
		end
		r.led_on = led;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			phase = '0;
			ticks = '0;
			pass_t0 = '0;
			slot_idx = SLOT_W'(NALL);
			upper_pass = 1'b0;
			for (int i = 0; i < NFILT; i++)
				filt[i] = '0;
			led = 1'b0;
			scan_en = 1'b1;
			led_en = 1'b0;
			step_results.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SCAN_ENABLE)
					scan_en = cfg_data[0];
				else if (cfg_index == REG_LED_ENABLE)
					led_en = cfg_data[0];
			end
			// results before items: a result never belongs to an item accepted this edge
			if (result_valid && !result_stall) begin
				got = result;
				if (step_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: %s", show(got));
				end else begin
					want = step_results.pop_front();
					if (got.period_start !== want.period_start ||
					    got.start_conv !== want.start_conv ||
					    got.channel !== want.channel ||
					    got.slot_write !== want.slot_write ||
					    got.slot !== want.slot ||
					    got.bank !== want.bank ||
					    got.stored_value !== want.stored_value ||
					    got.sequence_done !== want.sequence_done ||
					    got.led_on !== want.led_on ||
					    got.convert_ticks !== want.convert_ticks ||
					    got.dropped !== want.dropped) begin
						errors++;
						if (errors <= 10)
							$display("result mismatch: expected %s, got %s",
								show(want), show(got));
					end
				end
			end
			if (item_valid && !item_stall) begin
				sequence_step(item, want);
				step_results.push_back(want);
			end
		end
		pending = step_results.size();
	end

endmodule

// ----- tb/adc_scan_sequencer_test.sv -----
// Testbench top for the ADC scan sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module adc_scan_sequencer_test;
	import adc_seq_pkg::*;

	localparam int PERIOD = PERIOD_TICKS_DEF;
	localparam int HALF   = HALF_OFFSET_DEF;
	localparam int SLOTS  = NUM_ALL_DEF;
	localparam int LIMIT  = 200000;
	localparam int TAIL   = 8;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	item_t                 item;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int errors;
	int pending;
	int cycles = 0;
	int sent = 0;
	bit calm = 1'b0;
	bit scan_on = 1'b1;
	// stimulus-side view of the heartbeat and of the running pass
	int ph = 0;
	int left = 0;
	int style = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	adc_scan_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	adc_scan_sequencer_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending)
	);

	always @(negedge clk) begin
		result_stall <= !calm && ($urandom_range(0, 99) < 21);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return SAMPLE_W'($urandom_range(0, 4095));
	endfunction

	// called and returns at a falling edge
	task automatic put_item(input logic m, input logic [SAMPLE_W-1:0] s);
		item_t it;
		it.mode = m;
		it.sample = s;
		while (!calm && $urandom_range(0, 99) < 21) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (item_stall);
		@(negedge clk);
		sent++;
	endtask

	task automatic run_items(input int n, input int calm_n);
		int k;
		int first;
		first = sent;
		while (sent - first < n) begin
			calm = (sent - first) < calm_n;
			put_item(MODE_TICK, pick_sample());
			ph = (ph + 1 >= PERIOD) ? 0 : ph + 1;
			if (scan_on && (ph == 0 || (ph == HALF && left == 0))) begin
				left = SLOTS;
				// 0..6 quick pass, 7..8 slow pass that overruns, 9 pass left hanging
				style = $urandom_range(0, 9);
			end
			if (left > 0) begin
				k = 0;
				if (style < 7) begin
					if ($urandom_range(0, 99) < 60)
						k = $urandom_range(1, left);
				end else if (style < 9) begin
					if ($urandom_range(0, 99) < 12)
						k = 1;
				end
				repeat (k) put_item(MODE_SAMPLE, pick_sample());
				left -= k;
			end else if ($urandom_range(0, 99) < 3) begin
				put_item(MODE_SAMPLE, pick_sample());
			end
		end
		calm = 1'b0;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (TAIL) @(negedge clk);
	endtask

	task automatic set_regs(input logic scan, input logic led);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SCAN_ENABLE;
		cfg_data <= scan;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_index <= REG_LED_ENABLE;
		cfg_data <= led;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		scan_on = scan;
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// samples with no pass running, field extremes and alternating bit patterns
		put_item(MODE_SAMPLE, 12'h000);
		put_item(MODE_SAMPLE, 12'hFFF);
		put_item(MODE_SAMPLE, 12'hAAA);
		put_item(MODE_SAMPLE, 12'h555);

		run_items(350, 0);
		drain();
		set_regs(1'b1, 1'b1);
		run_items(350, 0);
		drain();
		// scans off: ticks only count, strays are dropped
		set_regs(1'b0, 1'b1);
		run_items(150, 0);
		drain();
		set_regs(1'b1, 1'b0);
		run_items(400, 250);
		drain();

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/adc_seq_pkg.sv
hw/rtl/adc_scan_sequencer.sv
tb/adc_scan_sequencer_check.sv
tb/adc_scan_sequencer_test.sv
